[rtl/core/triangle_plane_quadric_top_defines.svh]
// assertion macros shared by the rtl
`ifndef TRIANGLE_PLANE_QUADRIC_TOP_DEFINES_SVH
`define TRIANGLE_PLANE_QUADRIC_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPQ_ASSERT(lbl, prop, msg)
`define TPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/tpq_pkg.sv]
package tpq_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int PROD_W     = 66;
  localparam int MAG_W      = 65;
  localparam int LEN_W      = 7;
  localparam int M_W        = 30;
  localparam int SQ_W       = 60;
  localparam int RAD_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int SQRT_STEPS = 4;
  localparam int NUM_W      = 47;
  localparam int Q_W        = 17;
  localparam int DIV_STEPS  = 4;
  localparam int P_W        = 18;
  localparam int DP_W       = 50;
  localparam int DOT_W      = 52;
  localparam int PD_W       = 36;
  localparam int KF_W       = 72;
  localparam int COEF_W     = 48;
  localparam int K_W        = 64;
  localparam int LANES      = 3;
  localparam int ROWS       = 4;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 312;
  localparam int ROUND_HALF = 32768;

  typedef logic [1:0] row_t;
  localparam row_t ROW_FIRST = 2'd0;
  localparam row_t ROW_LAST  = 2'd3;

  typedef struct packed {
    logic                             degen;
    logic [ROWS-1:0][COEF_W-1:0]      coef;
    logic [ROWS-1:0][ROWS-1:0][K_W-1:0] quad;
  } tpq_row_set_t;

endpackage

[rtl/core/tpq_sqrt_pipe.sv]
module tpq_sqrt_pipe
  import tpq_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NST = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

  logic [NST-1:0]    vld_r;
  logic [RAD_W-1:0]  rad_r  [NST];
  logic [RAD_W-1:0]  rad_nxt [NST];
  logic [ROOT_W+1:0] rem_r  [NST];
  logic [ROOT_W+1:0] rem_nxt [NST];
  logic [ROOT_W-1:0] root_r [NST];
  logic [ROOT_W-1:0] root_nxt [NST];
  logic [SIDE_W-1:0] side_r [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam int PREV = (g == 0) ? 0 : g - 1;

    always_comb begin
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W+1:0] t;
      logic [ROOT_W-1:0] root;
      if (g == 0) begin
        rad  = in_rad;
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_r[PREV];
        rem  = rem_r[PREV];
        root = root_r[PREV];
      end
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (g * SQRT_STEPS + j < ROOT_W) begin
          // two radicand bits per step, trial is compared against 4*root+1
          trial = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
          t     = {root, 2'b01};
          rad   = rad << 2;
          if (trial >= t) begin
            rem  = trial - t;
            root = {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  = trial;
            root = {root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      rad_nxt[g]  = rad;
      rem_nxt[g]  = rem;
      root_nxt[g] = root;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g]  <= rad_nxt[g];
        rem_r[g]  <= rem_nxt[g];
        root_r[g] <= root_nxt[g];
        side_r[g] <= (g == 0) ? in_side : side_r[(g == 0) ? 0 : g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_root  = root_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

[rtl/core/tpq_div_pipe.sv]
module tpq_div_pipe
  import tpq_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [ROOT_W-1:0]           in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quot,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int NST = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

  logic [NST-1:0]                   vld_r;
  logic [LANES-1:0][Q_W-1:0]        bits_r  [NST];
  logic [LANES-1:0][Q_W-1:0]        bits_nxt [NST];
  logic [LANES-1:0][ROOT_W-1:0]     rem_r   [NST];
  logic [LANES-1:0][ROOT_W-1:0]     rem_nxt [NST];
  logic [LANES-1:0][Q_W-1:0]        quot_r  [NST];
  logic [LANES-1:0][Q_W-1:0]        quot_nxt [NST];
  logic [ROOT_W-1:0]                den_r   [NST];
  logic [SIDE_W-1:0]                side_r  [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam int PREV = (g == 0) ? 0 : g - 1;

    always_comb begin
      logic [LANES-1:0][Q_W-1:0]    bits;
      logic [LANES-1:0][ROOT_W-1:0] rem;
      logic [LANES-1:0][Q_W-1:0]    quot;
      logic [ROOT_W-1:0]            den;
      logic [ROOT_W:0]              trial;
      if (g == 0) begin
        den = in_den;
        for (int l = 0; l < LANES; l++) begin
          // quotient stays below 2^Q_W, so the upper part is below the divisor
          rem[l]  = ROOT_W'(in_num[l][NUM_W-1:Q_W]);
          bits[l] = in_num[l][Q_W-1:0];
          quot[l] = '0;
        end
      end else begin
        den  = den_r[PREV];
        rem  = rem_r[PREV];
        bits = bits_r[PREV];
        quot = quot_r[PREV];
      end
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          if (g * DIV_STEPS + j < Q_W) begin
            trial   = {rem[l], bits[l][Q_W-1]};
            bits[l] = bits[l] << 1;
            if (trial >= {1'b0, den}) begin
              rem[l]  = ROOT_W'(trial - {1'b0, den});
              quot[l] = {quot[l][Q_W-2:0], 1'b1};
            end else begin
              rem[l]  = trial[ROOT_W-1:0];
              quot[l] = {quot[l][Q_W-2:0], 1'b0};
            end
          end
        end
      end
      bits_nxt[g] = bits;
      rem_nxt[g]  = rem;
      quot_nxt[g] = quot;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bits_r[g] <= bits_nxt[g];
        rem_r[g]  <= rem_nxt[g];
        quot_r[g] <= quot_nxt[g];
        den_r[g]  <= (g == 0) ? in_den : den_r[(g == 0) ? 0 : g-1];
        side_r[g] <= (g == 0) ? in_side : side_r[(g == 0) ? 0 : g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quot  = quot_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

[rtl/core/tpq_emit.sv]
module tpq_emit
  import tpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  input  tpq_row_set_t          load_set,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]            out_tuser,
  output logic                  out_tlast
);

  logic         busy_r, busy_nxt;
  row_t         row_r, row_nxt;
  tpq_row_set_t set_r;
  logic         fire;

  assign fire     = busy_r && out_tready;
  assign can_load = !busy_r || (fire && row_r == ROW_LAST);

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (fire) begin
      row_nxt = row_r + 2'd1;
      if (row_r == ROW_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (load_valid && can_load) begin
      busy_nxt = 1'b1;
      row_nxt  = ROW_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= ROW_FIRST;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      set_r <= load_set;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = (row_r == ROW_LAST);
  assign out_tuser  = set_r.degen;
  assign out_tdata  = {6'b0, set_r.quad[row_r][3], set_r.quad[row_r][2],
                       set_r.quad[row_r][1], set_r.quad[row_r][0],
                       set_r.coef[row_r], row_r};

endmodule

[rtl/core/triangle_plane_quadric_top.sv]
// output: one result row a cycle while out_tready is high, from a four-row serializer
// throughput: the serializer loads a triangle as the last row of the one before goes out;
//   the pipeline (sqrt 8 stages, divide 5 stages) takes one per cycle unless stalled
// reset: synchronous active low, clears valid bits and the serializer, no data reset
`include "triangle_plane_quadric_top_defines.svh"
module triangle_plane_quadric_top
  import tpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_b_z, corner_c_x .. corner_c_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row_index, plane_coef, quad_col0, quad_col1, quad_col2, quad_col3, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic [0:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int SQ_SIDE_W  = 1 + LANES + LANES * M_W + LANES * COORD_W;
  localparam int DIV_SIDE_W = 1 + LANES + LANES * COORD_W;

  logic en, can_load;

  // stage 1: edge vectors
  logic                                  s1_v_r;
  logic signed [DIFF_W-1:0]              s1_u_r [LANES];
  logic signed [DIFF_W-1:0]              s1_w_r [LANES];
  logic [LANES-1:0][COORD_W-1:0]         s1_ca_r;
  // stage 2: cross partial products
  logic                                  s2_v_r;
  logic signed [PROD_W-1:0]              s2_pa_r [LANES];
  logic signed [PROD_W-1:0]              s2_pb_r [LANES];
  logic [LANES-1:0][COORD_W-1:0]         s2_ca_r;
  // stage 3: cross product as sign and magnitude
  logic                                  s3_v_r;
  logic [LANES-1:0][MAG_W-1:0]           s3_mag_r;
  logic [LANES-1:0]                      s3_neg_r;
  logic                                  s3_degen_r;
  logic [LANES-1:0][COORD_W-1:0]         s3_ca_r;
  // stage 4: bit length of the largest component
  logic                                  s4_v_r;
  logic [LEN_W-1:0]                      s4_len_r;
  logic [LANES-1:0][MAG_W-1:0]           s4_mag_r;
  logic [LANES-1:0]                      s4_neg_r;
  logic                                  s4_degen_r;
  logic [LANES-1:0][COORD_W-1:0]         s4_ca_r;
  // stage 5: scaled components
  logic                                  s5_v_r;
  logic [LANES-1:0][M_W-1:0]             s5_m_r;
  logic [LANES-1:0]                      s5_neg_r;
  logic                                  s5_degen_r;
  logic [LANES-1:0][COORD_W-1:0]         s5_ca_r;
  // stage 6: squares
  logic                                  s6_v_r;
  logic [SQ_W-1:0]                       s6_sq_r [LANES];
  logic [SQ_SIDE_W-1:0]                  s6_side_r;
  // stage 7: sum of squares
  logic                                  s7_v_r;
  logic [RAD_W-1:0]                      s7_sum_r;
  logic [SQ_SIDE_W-1:0]                  s7_side_r;

  logic                                  sq_v;
  logic [ROOT_W-1:0]                     sq_root;
  logic [SQ_SIDE_W-1:0]                  sq_side;
  logic                                  sq_degen;
  logic [LANES-1:0]                      sq_neg;
  logic [LANES-1:0][M_W-1:0]             sq_m;
  logic [LANES-1:0][COORD_W-1:0]         sq_ca;
  logic [LANES-1:0][NUM_W-1:0]           div_num;

  logic                                  dv_v;
  logic [LANES-1:0][Q_W-1:0]             dv_quot;
  logic [DIV_SIDE_W-1:0]                 dv_side;
  logic                                  dv_degen;
  logic [LANES-1:0]                      dv_neg;
  logic [LANES-1:0][COORD_W-1:0]         dv_ca;

  // signed normal components
  logic                                  sp_v_r;
  logic signed [P_W-1:0]                 sp_p_r [LANES];
  logic [LANES-1:0][COORD_W-1:0]         sp_ca_r;
  logic                                  sp_degen_r;
  // products with the first corner
  logic                                  sm_v_r;
  logic signed [DP_W-1:0]                sm_dp_r [LANES];
  logic signed [P_W-1:0]                 sm_p_r [LANES];
  logic                                  sm_degen_r;
  // dot product
  logic                                  sd_v_r;
  logic signed [DOT_W-1:0]               sd_dot_r;
  logic signed [P_W-1:0]                 sd_p_r [LANES];
  logic                                  sd_degen_r;
  // plane offset
  logic                                  so_v_r;
  logic signed [PD_W-1:0]                so_p_r [ROWS];
  logic                                  so_degen_r;
  // full quadric products
  logic                                  sk_v_r;
  logic signed [KF_W-1:0]                sk_k_r [ROWS][ROWS];
  logic signed [PD_W-1:0]                sk_p_r [ROWS];
  logic                                  sk_degen_r;
  // saturated row set
  logic                                  ss_v_r;
  tpq_row_set_t                          ss_set_r;

  logic [LANES-1:0][MAG_W-1:0]           s3_mag_nxt;
  logic [LANES-1:0]                      s3_neg_nxt;
  logic [LEN_W-1:0]                      s4_len_nxt;
  logic signed [PD_W-1:0]                so_d_nxt;
  tpq_row_set_t                          ss_set_nxt;

  assign en        = !ss_v_r || can_load;
  assign in_tready = en;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      sp_v_r <= 1'b0;
      sm_v_r <= 1'b0;
      sd_v_r <= 1'b0;
      so_v_r <= 1'b0;
      sk_v_r <= 1'b0;
      ss_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      sp_v_r <= dv_v;
      sm_v_r <= sp_v_r;
      sd_v_r <= sm_v_r;
      so_v_r <= sd_v_r;
      sk_v_r <= so_v_r;
      ss_v_r <= sk_v_r;
    end
  end

  // cross product front end
  always_comb begin
    logic signed [PROD_W-1:0] cr;
    for (int i = 0; i < LANES; i++) begin
      cr            = s2_pa_r[i] - s2_pb_r[i];
      s3_neg_nxt[i] = cr[PROD_W-1];
      s3_mag_nxt[i] = cr[PROD_W-1] ? MAG_W'(-cr) : cr[MAG_W-1:0];
    end
  end

  always_comb begin
    logic [MAG_W-1:0] any_bits;
    any_bits   = s3_mag_r[0] | s3_mag_r[1] | s3_mag_r[2];
    s4_len_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (any_bits[i]) begin
        s4_len_nxt = LEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s1_u_r[i] <= $signed({in_tdata[i*COORD_W + COORD_W-1], in_tdata[i*COORD_W +: COORD_W]})
                   - $signed({in_tdata[(LANES+i)*COORD_W + COORD_W-1],
                              in_tdata[(LANES+i)*COORD_W +: COORD_W]});
        s1_w_r[i] <= $signed({in_tdata[(LANES+i)*COORD_W + COORD_W-1],
                              in_tdata[(LANES+i)*COORD_W +: COORD_W]})
                   - $signed({in_tdata[(2*LANES+i)*COORD_W + COORD_W-1],
                              in_tdata[(2*LANES+i)*COORD_W +: COORD_W]});
        s1_ca_r[i] <= in_tdata[i*COORD_W +: COORD_W];
      end

      s2_pa_r[0] <= s1_u_r[1] * s1_w_r[2];
      s2_pb_r[0] <= s1_u_r[2] * s1_w_r[1];
      s2_pa_r[1] <= s1_u_r[2] * s1_w_r[0];
      s2_pb_r[1] <= s1_u_r[0] * s1_w_r[2];
      s2_pa_r[2] <= s1_u_r[0] * s1_w_r[1];
      s2_pb_r[2] <= s1_u_r[1] * s1_w_r[0];
      s2_ca_r    <= s1_ca_r;

      s3_mag_r   <= s3_mag_nxt;
      s3_neg_r   <= s3_neg_nxt;
      s3_degen_r <= (s3_mag_nxt == '0);
      s3_ca_r    <= s2_ca_r;

      s4_len_r   <= s4_len_nxt;
      s4_mag_r   <= s3_mag_r;
      s4_neg_r   <= s3_neg_r;
      s4_degen_r <= s3_degen_r;
      s4_ca_r    <= s3_ca_r;

      // largest component lands in [2^29, 2^30); right shifts truncate
      for (int i = 0; i < LANES; i++) begin
        s5_m_r[i] <= M_W'({s4_mag_r[i], {M_W{1'b0}}} >> s4_len_r);
      end
      s5_neg_r   <= s4_neg_r;
      s5_degen_r <= s4_degen_r;
      s5_ca_r    <= s4_ca_r;

      for (int i = 0; i < LANES; i++) begin
        s6_sq_r[i] <= s5_m_r[i] * s5_m_r[i];
      end
      s6_side_r <= {s5_degen_r, s5_neg_r, s5_m_r, s5_ca_r};

      s7_sum_r  <= RAD_W'(s6_sq_r[0]) + RAD_W'(s6_sq_r[1]) + RAD_W'(s6_sq_r[2]);
      s7_side_r <= s6_side_r;
    end
  end

  tpq_sqrt_pipe #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_rad    (s7_sum_r),
    .in_side   (s7_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign {sq_degen, sq_neg, sq_m, sq_ca} = sq_side;

  // rounding term r/2 added before the divide
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      div_num[i] = NUM_W'({sq_m[i], 16'b0}) + NUM_W'(sq_root >> 1);
    end
  end

  tpq_div_pipe #(
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_num    (div_num),
    .in_den    (sq_root),
    .in_side   ({sq_degen, sq_neg, sq_ca}),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  assign {dv_degen, dv_neg, dv_ca} = dv_side;

  always_comb begin
    logic [DOT_W-1:0] mag;
    logic [DOT_W-1:0] rnd;
    logic signed [DOT_W-1:0] dn;
    dn  = -sd_dot_r;
    mag = dn[DOT_W-1] ? DOT_W'(-dn) : DOT_W'(dn);
    rnd = mag + DOT_W'(ROUND_HALF);
    so_d_nxt = dn[DOT_W-1] ? -$signed(PD_W'(rnd[DOT_W-1:16])) : $signed(PD_W'(rnd[DOT_W-1:16]));
  end

  always_comb begin
    ss_set_nxt.degen = sk_degen_r;
    for (int i = 0; i < ROWS; i++) begin
      ss_set_nxt.coef[i] = COEF_W'(sk_p_r[i]);
      for (int j = 0; j < ROWS; j++) begin
        if ((sk_k_r[i][j][KF_W-1:K_W-1] == '0) || (sk_k_r[i][j][KF_W-1:K_W-1] == '1)) begin
          ss_set_nxt.quad[i][j] = sk_k_r[i][j][K_W-1:0];
        end else if (sk_k_r[i][j][KF_W-1]) begin
          ss_set_nxt.quad[i][j] = {1'b1, {(K_W-1){1'b0}}};
        end else begin
          ss_set_nxt.quad[i][j] = {1'b0, {(K_W-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        if (dv_degen) begin
          sp_p_r[i] <= '0;
        end else if (dv_neg[i]) begin
          sp_p_r[i] <= -$signed({1'b0, dv_quot[i]});
        end else begin
          sp_p_r[i] <= $signed({1'b0, dv_quot[i]});
        end
      end
      sp_ca_r    <= dv_ca;
      sp_degen_r <= dv_degen;

      for (int i = 0; i < LANES; i++) begin
        sm_dp_r[i] <= sp_p_r[i] * $signed(sp_ca_r[i]);
        sm_p_r[i]  <= sp_p_r[i];
      end
      sm_degen_r <= sp_degen_r;

      sd_dot_r <= DOT_W'(sm_dp_r[0]) + DOT_W'(sm_dp_r[1]) + DOT_W'(sm_dp_r[2]);
      for (int i = 0; i < LANES; i++) begin
        sd_p_r[i] <= sm_p_r[i];
      end
      sd_degen_r <= sm_degen_r;

      for (int i = 0; i < LANES; i++) begin
        so_p_r[i] <= PD_W'(sd_p_r[i]);
      end
      so_p_r[ROWS-1] <= so_d_nxt;
      so_degen_r     <= sd_degen_r;

      for (int i = 0; i < ROWS; i++) begin
        for (int j = 0; j < ROWS; j++) begin
          sk_k_r[i][j] <= so_p_r[i] * so_p_r[j];
        end
        sk_p_r[i] <= so_p_r[i];
      end
      sk_degen_r <= so_degen_r;

      ss_set_r <= ss_set_nxt;
    end
  end

  tpq_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (ss_v_r),
    .load_set   (ss_set_r),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `TPQ_ASSERT(a_last_on_row3, out_tvalid && out_tlast |-> out_tdata[1:0] == ROW_LAST, "tlast off row 3")
  `TPQ_ASSERT(a_degen_zero, out_tvalid && out_tuser[0] |-> out_tdata[305:2] == '0, "degenerate row not zero")
  `TPQ_ASSERT(a_row_step, out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1, "row sequence broken")
  `TPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
